// ===== design/ivs_pkg.sv =====
// ----------------------------------------------------------------------------
// ivs_pkg - shared types and constants for the I-V sweep sequencer
// Transaction payloads, configuration bundle, phase and status codes.
// ----------------------------------------------------------------------------
package ivs_pkg;

  // ADC sample width and DAC limits
  localparam int unsigned ADC_BITS = 12;
  localparam int unsigned DAC_W    = 11;
  localparam int unsigned DAC_TOP  = 1023;
  localparam int unsigned LIMIT_FLOOR = 900;

  // APB map: register i at byte address 4*i
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  typedef logic [ADC_BITS-1:0] adc_code_t;
  typedef logic [DAC_W-1:0]    dac_code_t;

  // Register indexes
  typedef enum logic [2:0] {
    REG_BIDIRECTIONAL = 3'd0,
    REG_USER_LIMIT    = 3'd1,
    REG_USER_LIMIT_EN = 3'd2,
    REG_ZERO_MARGIN   = 3'd3,
    REG_MAX_POS_CUR   = 3'd4,
    REG_MAX_NEG_CUR   = 3'd5,
    REG_TOP_DAC       = 3'd6,
    REG_BOTTOM_DAC    = 3'd7
  } ivs_reg_t;

  // Input operation codes
  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_START   = 1'b1;

  typedef enum logic [1:0] {
    STATUS_NONE     = 2'd0,
    STATUS_STARTED  = 2'd1,
    STATUS_ENDED    = 2'd2,
    STATUS_NO_POWER = 2'd3
  } ivs_status_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_ZERO_PRE = 3'd1,
    PH_UP       = 3'd2,
    PH_ZERO_MID = 3'd3,
    PH_DOWN     = 3'd4,
    PH_ZERO_END = 3'd5
  } ivs_phase_t;

  typedef struct packed {
    logic      bidirectional;
    adc_code_t user_current_limit;
    logic      user_limit_enable;
    adc_code_t zero_margin;
    adc_code_t max_positive_current;
    adc_code_t max_negative_current;
    logic [9:0] top_dac_code;
    logic [9:0] bottom_dac_code;
  } ivs_cfg_t;

  typedef struct packed {
    logic      op;
    logic      supply_present;
    adc_code_t reference_code;
    adc_code_t dev_voltage;
    adc_code_t dev_current;
  } ivs_item_t;

  typedef struct packed {
    dac_code_t   dac_code;
    logic        report_valid;
    adc_code_t   report_current;
    adc_code_t   report_voltage;
    ivs_status_t status;
    logic        busy_res;
  } ivs_result_t;

endpackage

// ===== design/ivs_regs.sv =====
// ----------------------------------------------------------------------------
// ivs_regs - APB configuration registers
// Eight sweep settings, written in the APB access phase, read back as is.
// ----------------------------------------------------------------------------
module ivs_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ivs_pkg::PADDR_W-1:0]   paddr,
  input  logic [ivs_pkg::PDATA_W-1:0]   pwdata,
  output logic [ivs_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output ivs_pkg::ivs_cfg_t             cfg
);
  import ivs_pkg::*;

  ivs_reg_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = ivs_reg_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bidirectional        <= 1'b1;
      cfg.user_current_limit   <= '0;
      cfg.user_limit_enable    <= 1'b0;
      cfg.zero_margin          <= 12'd8;
      cfg.max_positive_current <= 12'd4000;
      cfg.max_negative_current <= 12'd95;
      cfg.top_dac_code         <= 10'd1022;
      cfg.bottom_dac_code      <= 10'd1;
    end else if (wr) begin
      unique case (idx)
        REG_BIDIRECTIONAL: cfg.bidirectional        <= pwdata[0];
        REG_USER_LIMIT:    cfg.user_current_limit   <= pwdata[ADC_BITS-1:0];
        REG_USER_LIMIT_EN: cfg.user_limit_enable    <= pwdata[0];
        REG_ZERO_MARGIN:   cfg.zero_margin          <= pwdata[ADC_BITS-1:0];
        REG_MAX_POS_CUR:   cfg.max_positive_current <= pwdata[ADC_BITS-1:0];
        REG_MAX_NEG_CUR:   cfg.max_negative_current <= pwdata[ADC_BITS-1:0];
        REG_TOP_DAC:       cfg.top_dac_code         <= pwdata[9:0];
        REG_BOTTOM_DAC:    cfg.bottom_dac_code      <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_BIDIRECTIONAL: prdata[0] = cfg.bidirectional;
      REG_USER_LIMIT:    prdata[ADC_BITS-1:0] = cfg.user_current_limit;
      REG_USER_LIMIT_EN: prdata[0] = cfg.user_limit_enable;
      REG_ZERO_MARGIN:   prdata[ADC_BITS-1:0] = cfg.zero_margin;
      REG_MAX_POS_CUR:   prdata[ADC_BITS-1:0] = cfg.max_positive_current;
      REG_MAX_NEG_CUR:   prdata[ADC_BITS-1:0] = cfg.max_negative_current;
      REG_TOP_DAC:       prdata[9:0] = cfg.top_dac_code;
      REG_BOTTOM_DAC:    prdata[9:0] = cfg.bottom_dac_code;
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== design/ivs_core.sv =====
// ----------------------------------------------------------------------------
// ivs_core - sweep phase machine and DAC stepping
// Holds the sweep state; computes the result of the registered transaction
// and commits the new state when fire is high.
// ----------------------------------------------------------------------------
module ivs_core (
  input  logic                clk,
  input  logic                rst,
  input  ivs_pkg::ivs_cfg_t   cfg,
  input  ivs_pkg::ivs_item_t  item,
  input  logic                fire,
  output ivs_pkg::ivs_result_t result
);
  import ivs_pkg::*;

  ivs_phase_t phase, phase_next;
  dac_code_t  dac_setting, dac_setting_next;
  adc_code_t  latched_reference, latched_reference_next;
  logic       reference_latched_flag, reference_latched_flag_next;

  // zeroing step terms
  adc_code_t            r;
  logic [ADC_BITS:0]    r_hi, v_hi;
  dac_code_t            zdac;
  logic                 in_margin;
  logic                 over_cur;
  dac_code_t            top_ext, bottom_ext;

  assign top_ext    = {1'b0, cfg.top_dac_code};
  assign bottom_ext = {1'b0, cfg.bottom_dac_code};

  always_comb begin
    r    = reference_latched_flag ? latched_reference : item.reference_code;
    r_hi = {1'b0, r} + {1'b0, cfg.zero_margin};
    v_hi = {1'b0, item.dev_voltage} + {1'b0, cfg.zero_margin};
    in_margin = !(({1'b0, item.dev_voltage} > r_hi) || (v_hi < {1'b0, r}));
    if (item.dev_voltage > r && dac_setting != '0) begin
      zdac = dac_setting - 1'b1;
    end else if (item.dev_voltage < r && dac_setting <= DAC_W'(DAC_TOP)) begin
      zdac = dac_setting + 1'b1;
    end else begin
      zdac = dac_setting;
    end
  end

  // over-current check
  always_comb begin
    if (cfg.user_limit_enable && cfg.user_current_limit > ADC_BITS'(LIMIT_FLOOR)) begin
      over_cur = item.dev_current > cfg.user_current_limit;
    end else begin
      over_cur = (item.dev_current > cfg.max_positive_current) ||
                 (item.dev_current < cfg.max_negative_current);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase                  <= PH_IDLE;
      dac_setting            <= '0;
      latched_reference      <= '0;
      reference_latched_flag <= 1'b0;
    end else if (fire) begin
      phase                  <= phase_next;
      dac_setting            <= dac_setting_next;
      latched_reference      <= latched_reference_next;
      reference_latched_flag <= reference_latched_flag_next;
    end
  end

  // next state and result
  always_comb begin
    phase_next                  = phase;
    dac_setting_next            = dac_setting;
    latched_reference_next      = latched_reference;
    reference_latched_flag_next = reference_latched_flag;
    result                      = '0;

    if (item.op == OP_START) begin
      if (phase == PH_IDLE) begin
        if (!item.supply_present) begin
          result.status = STATUS_NO_POWER;
        end else begin
          phase_next                  = PH_ZERO_PRE;
          reference_latched_flag_next = 1'b0;
          result.status               = STATUS_STARTED;
        end
      end
    end else begin
      unique case (phase)
        PH_ZERO_PRE: begin
          latched_reference_next      = r;
          reference_latched_flag_next = !in_margin;
          dac_setting_next            = zdac;
          if (in_margin) begin
            if (zdac <= top_ext) begin
              dac_setting_next = zdac + 1'b1;
              phase_next       = PH_UP;
            end else begin
              phase_next = PH_ZERO_MID;
            end
          end
        end
        PH_UP: begin
          result.report_valid   = 1'b1;
          result.report_current = item.dev_current;
          result.report_voltage = item.dev_voltage;
          if (over_cur || dac_setting > top_ext) begin
            phase_next                  = PH_ZERO_MID;
            reference_latched_flag_next = 1'b0;
          end else begin
            dac_setting_next = dac_setting + 1'b1;
          end
        end
        PH_ZERO_MID: begin
          latched_reference_next      = r;
          reference_latched_flag_next = !in_margin;
          dac_setting_next            = zdac;
          if (in_margin) begin
            if (!cfg.bidirectional) begin
              phase_next    = PH_IDLE;
              result.status = STATUS_ENDED;
            end else if (zdac > bottom_ext) begin
              dac_setting_next = zdac - 1'b1;
              phase_next       = PH_DOWN;
            end else begin
              phase_next = PH_ZERO_END;
            end
          end
        end
        PH_DOWN: begin
          result.report_valid   = 1'b1;
          result.report_current = item.dev_current;
          result.report_voltage = item.dev_voltage;
          if (over_cur || dac_setting <= bottom_ext) begin
            phase_next                  = PH_ZERO_END;
            reference_latched_flag_next = 1'b0;
          end else begin
            dac_setting_next = dac_setting - 1'b1;
          end
        end
        PH_ZERO_END: begin
          latched_reference_next      = r;
          reference_latched_flag_next = !in_margin;
          dac_setting_next            = zdac;
          if (in_margin) begin
            phase_next    = PH_IDLE;
            result.status = STATUS_ENDED;
          end
        end
        default: begin
          // idle: keep the device voltage tracking the reference
          phase_next                  = PH_IDLE;
          latched_reference_next      = r;
          reference_latched_flag_next = !in_margin;
          dac_setting_next            = zdac;
        end
      endcase
    end

    result.dac_code = dac_setting_next;
    result.busy_res = (phase_next != PH_IDLE);
  end

endmodule

// ===== design/iv_curve_sweep_sequencer.sv =====
// ----------------------------------------------------------------------------
// iv_curve_sweep_sequencer - curve tracer sweep sequencer, top level
// Input register, sequencer core, result register and APB settings.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the result side keeps taking, and
// returns exactly one result for each: the transaction is captured in an
// input register, the phase machine works out the DAC code, report and
// status combinationally, and the result is offered from an output register
// loaded from the core when the input register moves on. The state update is
// compare and increment logic; the input stalls only while the input register
// is full and the result register holds a stalled result. Settings must be
// written over APB only while no transaction is in flight; the block itself
// does not enforce this. No clearing pass runs after reset.
module iv_curve_sweep_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  ivs_pkg::ivs_item_t            item,
  output logic                          res_valid,
  input  logic                          res_stall,
  output ivs_pkg::ivs_result_t          result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ivs_pkg::PADDR_W-1:0]   paddr,
  input  logic [ivs_pkg::PDATA_W-1:0]   pwdata,
  output logic [ivs_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import ivs_pkg::*;

  ivs_cfg_t    cfg;
  logic        s1_valid;
  ivs_item_t   s1_item;
  ivs_result_t core_result;
  logic        s1_fire;
  logic        accept;

  ivs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake: stage 1 moves on whenever the result register can take it
  assign s1_fire    = s1_valid && !(res_valid && res_stall);
  assign item_stall = s1_valid && !s1_fire;
  assign accept     = item_valid && !item_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !s1_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
    end
  end

  ivs_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (s1_item),
    .fire   (s1_fire),
    .result (core_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      result <= core_result;
    end
  end

`ifndef NO_ASSERTIONS
  // a reported sample is always taken mid-sweep
  a_report_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && result.report_valid |-> result.busy_res)
    else $error("report outside of a sweep");

  // the end of a sweep leaves the sequencer idle
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && (result.status == STATUS_ENDED) |-> !result.busy_res)
    else $error("sweep ended but still busy");

  // a started sweep is busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && (result.status == STATUS_STARTED) |-> result.busy_res)
    else $error("sweep started but not busy");

  // input is only held off by an occupied stage that cannot drain
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid && res_valid && res_stall)
    else $error("input stalled without cause");
`endif

endmodule

// ===== bench/sweep_checker.sv =====
// ----------------------------------------------------------------------------
// sweep_checker - predicts and checks every sweep sequencer result
// Follows the APB writes and the item channel to advance its own copy of the
// sweep sequencer, queues the expected DAC steps and compares each accepted
// result with the oldest one.
// ----------------------------------------------------------------------------
module sweep_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_stall,
  input  ivs_pkg::ivs_item_t            item,
  input  logic                          res_valid,
  input  logic                          res_stall,
  input  ivs_pkg::ivs_result_t          result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [ivs_pkg::PADDR_W-1:0]   paddr,
  input  logic [ivs_pkg::PDATA_W-1:0]   pwdata,
  output int                            fail_count,
  output int                            pending
);
  import ivs_pkg::*;

  // Settings copy and sequencer state of the prediction
  ivs_cfg_t   cfg;
  ivs_phase_t sweep_phase;
  dac_code_t  dac_level;
  adc_code_t  held_reference;
  logic       reference_held;

  ivs_result_t expected_steps[$];
  int          mismatches;

  // One zeroing step; returns 1 once the voltage sits within the margin
  function automatic bit zeroing_step(adc_code_t ref_in, adc_code_t v);
    int r;
    int vi;
    int m;
    if (!reference_held) begin
      held_reference = ref_in;
      reference_held = 1'b1;
    end
    r  = held_reference;
    vi = v;
    m  = cfg.zero_margin;
    if (vi > r && dac_level > 0) begin
      dac_level = dac_level - 1'b1;
    end else if (vi < r && dac_level <= DAC_TOP) begin
      dac_level = dac_level + 1'b1;
    end
    if (vi > r + m || vi + m < r) return 1'b0;
    reference_held = 1'b0;
    return 1'b1;
  endfunction

  // User limit wins only when enabled and above the floor
  function automatic bit current_tripped(adc_code_t i);
    if (cfg.user_limit_enable && cfg.user_current_limit > LIMIT_FLOOR)
      return i > cfg.user_current_limit;
    return i > cfg.max_positive_current || i < cfg.max_negative_current;
  endfunction

  // Advance the sequencer by one transaction and return its result
  function automatic ivs_result_t predict_sweep_step(ivs_item_t it);
    ivs_result_t r;
    r = '0;
    if (it.op == OP_START) begin
      if (sweep_phase == PH_IDLE) begin
        if (!it.supply_present) begin
          r.status = STATUS_NO_POWER;
        end else begin
          sweep_phase    = PH_ZERO_PRE;
          reference_held = 1'b0;
          r.status       = STATUS_STARTED;
        end
      end
    end else begin
      case (sweep_phase)
        PH_ZERO_PRE: begin
          if (zeroing_step(it.reference_code, it.dev_voltage)) begin
            if (dac_level <= cfg.top_dac_code) begin
              dac_level   = dac_level + 1'b1;
              sweep_phase = PH_UP;
            end else begin
              sweep_phase = PH_ZERO_MID;
            end
          end
        end
        PH_UP: begin
          r.report_valid   = 1'b1;
          r.report_current = it.dev_current;
          r.report_voltage = it.dev_voltage;
          if (current_tripped(it.dev_current) || dac_level > cfg.top_dac_code) begin
            sweep_phase    = PH_ZERO_MID;
            reference_held = 1'b0;
          end else begin
            dac_level = dac_level + 1'b1;
          end
        end
        PH_ZERO_MID: begin
          if (zeroing_step(it.reference_code, it.dev_voltage)) begin
            if (!cfg.bidirectional) begin
              sweep_phase = PH_IDLE;
              r.status    = STATUS_ENDED;
            end else if (dac_level > cfg.bottom_dac_code) begin
              dac_level   = dac_level - 1'b1;
              sweep_phase = PH_DOWN;
            end else begin
              sweep_phase = PH_ZERO_END;
            end
          end
        end
        PH_DOWN: begin
          r.report_valid   = 1'b1;
          r.report_current = it.dev_current;
          r.report_voltage = it.dev_voltage;
          if (current_tripped(it.dev_current) || dac_level <= cfg.bottom_dac_code) begin
            sweep_phase    = PH_ZERO_END;
            reference_held = 1'b0;
          end else begin
            dac_level = dac_level - 1'b1;
          end
        end
        PH_ZERO_END: begin
          if (zeroing_step(it.reference_code, it.dev_voltage)) begin
            sweep_phase = PH_IDLE;
            r.status    = STATUS_ENDED;
          end
        end
        default: begin
          // idle ticks keep tracking the reference
          sweep_phase = PH_IDLE;
          void'(zeroing_step(it.reference_code, it.dev_voltage));
        end
      endcase
    end
    r.dac_code = dac_level;
    r.busy_res = (sweep_phase != PH_IDLE);
    return r;
  endfunction

  // Watch settings, transactions and results on every rising edge
  always @(posedge clk) begin
    ivs_result_t exp_res;
    if (rst) begin
      cfg.bidirectional        = 1'b1;
      cfg.user_current_limit   = '0;
      cfg.user_limit_enable    = 1'b0;
      cfg.zero_margin          = 12'd8;
      cfg.max_positive_current = 12'd4000;
      cfg.max_negative_current = 12'd95;
      cfg.top_dac_code         = 10'd1022;
      cfg.bottom_dac_code      = 10'd1;
      sweep_phase    = PH_IDLE;
      dac_level      = '0;
      held_reference = '0;
      reference_held = 1'b0;
      fail_count     = 0;
      mismatches     = 0;
      expected_steps.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (ivs_reg_t'(paddr[4:2]))
          REG_BIDIRECTIONAL: cfg.bidirectional        = pwdata[0];
          REG_USER_LIMIT:    cfg.user_current_limit   = pwdata[11:0];
          REG_USER_LIMIT_EN: cfg.user_limit_enable    = pwdata[0];
          REG_ZERO_MARGIN:   cfg.zero_margin          = pwdata[11:0];
          REG_MAX_POS_CUR:   cfg.max_positive_current = pwdata[11:0];
          REG_MAX_NEG_CUR:   cfg.max_negative_current = pwdata[11:0];
          REG_TOP_DAC:       cfg.top_dac_code         = pwdata[9:0];
          REG_BOTTOM_DAC:    cfg.bottom_dac_code      = pwdata[9:0];
          default: ;
        endcase
      end

      // accepted input transaction
      if (item_valid && !item_stall)
        expected_steps.push_back(predict_sweep_step(item));

      // accepted result
      if (res_valid && !res_stall) begin
        if (expected_steps.size() == 0) begin
          fail_count = fail_count + 1;
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("unexpected result: dac %0d status %0d busy %0d",
                     result.dac_code, result.status, result.busy_res);
        end else begin
          exp_res = expected_steps.pop_front();
          if (result.dac_code       !== exp_res.dac_code       ||
              result.report_valid   !== exp_res.report_valid   ||
              result.report_current !== exp_res.report_current ||
              result.report_voltage !== exp_res.report_voltage ||
              result.status         !== exp_res.status         ||
              result.busy_res       !== exp_res.busy_res) begin
            fail_count = fail_count + 1;
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display({"mismatch (exp/got): dac %0d/%0d rv %0d/%0d cur %0d/%0d",
                        " volt %0d/%0d status %0d/%0d busy %0d/%0d"},
                       exp_res.dac_code, result.dac_code,
                       exp_res.report_valid, result.report_valid,
                       exp_res.report_current, result.report_current,
                       exp_res.report_voltage, result.report_voltage,
                       exp_res.status, result.status,
                       exp_res.busy_res, result.busy_res);
          end
        end
      end
    end
    pending = expected_steps.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - stimulus and verdict for the I-V sweep sequencer
// Runs a directed walk through one full sweep, then random sweeps under
// several register settings and idle/stall mixes; sweep_checker does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
  import ivs_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 180;
  localparam int HOLD_CYCLES = 80;
  localparam int HOLD_AT     = 55;
  localparam int WATCHDOG    = 4000;
  localparam int DRAIN_WAIT  = 4;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  ivs_item_t           item       = '0;
  logic                res_valid;
  logic                res_stall  = 1'b0;
  ivs_result_t         result;
  logic                psel       = 1'b0;
  logic                penable    = 1'b0;
  logic                pwrite     = 1'b0;
  logic [PADDR_W-1:0]  paddr      = '0;
  logic [PDATA_W-1:0]  pwdata     = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  int fail_count;
  int pending;

  // Stimulus controls
  ivs_cfg_t  stim_cfg;
  ivs_cfg_t  settings[PHASES];
  adc_code_t sweep_ref   = '0;
  int        idle_pct    = 0;
  int        stall_pct   = 0;
  logic      hold_done   = 1'b0;
  int        hold_left   = 0;
  int        items_sent  = 0;
  int        quiet_cycles = 0;

  always #2 clk = ~clk;

  iv_curve_sweep_sequencer uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .res_valid(res_valid), .res_stall(res_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sweep_checker sweep_check (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .res_valid(res_valid), .res_stall(res_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  // Result side: random stalls, or one long hold-off once enough items went in
  always begin
    @(negedge clk);
    if (!hold_done && items_sent == HOLD_AT) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      res_stall = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      res_stall = (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: cycles without any accepted transaction
  always @(posedge clk) begin
    if (!rst) begin
      if ((item_valid && !item_stall) || (res_valid && !res_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic ivs_cfg_t make_settings(logic bidir, int ulim, logic uen, int margin,
                                             int max_pos, int max_neg, int top, int bottom);
    ivs_cfg_t c;
    c.bidirectional        = bidir;
    c.user_current_limit   = ulim[11:0];
    c.user_limit_enable    = uen;
    c.zero_margin          = margin[11:0];
    c.max_positive_current = max_pos[11:0];
    c.max_negative_current = max_neg[11:0];
    c.top_dac_code         = top[9:0];
    c.bottom_dac_code      = bottom[9:0];
    return c;
  endfunction

  function automatic ivs_item_t make_item(logic op, logic supply, int ref_code,
                                          int volt, int cur);
    ivs_item_t it;
    it.op             = op;
    it.supply_present = supply;
    it.reference_code = ref_code[11:0];
    it.dev_voltage    = volt[11:0];
    it.dev_current    = cur[11:0];
    return it;
  endfunction

  // Random transaction shaped to carry sweeps through all phases
  function automatic ivs_item_t next_item();
    ivs_item_t it;
    int span;
    int vv;
    int lo;
    int hi;
    it = '0;
    it.supply_present = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 6) begin
      it.op = OP_START;
      it.supply_present = ($urandom_range(0, 99) < 85);
      case ($urandom_range(0, 9))
        0:       sweep_ref = '0;
        1:       sweep_ref = '1;
        default: sweep_ref = 12'($urandom_range(0, 4095));
      endcase
      it.reference_code = 12'($urandom_range(0, 4095));
      it.dev_voltage    = 12'($urandom_range(0, 4095));
      it.dev_current    = 12'($urandom_range(0, 4095));
      return it;
    end
    it.op = OP_MEASURE;
    it.reference_code = ($urandom_range(0, 99) < 80) ? sweep_ref : 12'($urandom_range(0, 4095));
    // voltage mostly near the sweep reference so zeroing can finish
    if ($urandom_range(0, 99) < 75) begin
      span = (stim_cfg.zero_margin > 50) ? 52 : int'(stim_cfg.zero_margin) + 2;
      vv = int'(sweep_ref) + int'($urandom_range(0, 2 * span)) - span;
      if (vv < 0) vv = 0;
      if (vv > 4095) vv = 4095;
      it.dev_voltage = vv[11:0];
    end else begin
      it.dev_voltage = 12'($urandom_range(0, 4095));
    end
    // current mostly inside the active window
    if (stim_cfg.user_limit_enable && stim_cfg.user_current_limit > LIMIT_FLOOR) begin
      lo = 0;
      hi = stim_cfg.user_current_limit;
    end else begin
      lo = stim_cfg.max_negative_current;
      hi = stim_cfg.max_positive_current;
    end
    if (lo <= hi && $urandom_range(0, 99) < 88)
      it.dev_current = 12'($urandom_range(lo, hi));
    else
      it.dev_current = 12'($urandom_range(0, 4095));
    return it;
  endfunction

  task automatic apb_write(input ivs_reg_t idx, input logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic write_settings(input ivs_cfg_t c);
    apb_write(REG_BIDIRECTIONAL, PDATA_W'(c.bidirectional));
    apb_write(REG_USER_LIMIT,    PDATA_W'(c.user_current_limit));
    apb_write(REG_USER_LIMIT_EN, PDATA_W'(c.user_limit_enable));
    apb_write(REG_ZERO_MARGIN,   PDATA_W'(c.zero_margin));
    apb_write(REG_MAX_POS_CUR,   PDATA_W'(c.max_positive_current));
    apb_write(REG_MAX_NEG_CUR,   PDATA_W'(c.max_negative_current));
    apb_write(REG_TOP_DAC,       PDATA_W'(c.top_dac_code));
    apb_write(REG_BOTTOM_DAC,    PDATA_W'(c.bottom_dac_code));
    stim_cfg = c;
  endtask

  // Offer one transaction; valid stays up after acceptance
  task automatic send_item(input ivs_item_t x);
    @(negedge clk);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item       = x;
    item_valid = 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent = items_sent + 1;
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk);
    item_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    settings[0] = make_settings(1'b1, 0,    1'b0, 8,    4000, 95,   24,   3);
    settings[1] = make_settings(1'b0, 3000, 1'b1, 0,    4000, 95,   40,   1);
    settings[2] = make_settings(1'b1, 900,  1'b1, 5,    4095, 0,    0,    1023);
    settings[3] = make_settings(1'b1, 0,    1'b0, 4095, 3500, 500,  1023, 0);
    settings[4] = make_settings(1'b1, 4095, 1'b1, 20,   4000, 95,   15,   10);
    settings[5] = make_settings(1'b1, 100,  1'b0, 3,    0,    4095, 512,  500);
    settings[6] = make_settings(1'b1, 901,  1'b1, 2,    4000, 95,   30,   0);
    settings[7] = make_settings(1'b1, 0,    1'b0, 8,    4000, 95,   1022, 1);

    // reset
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed walk through one full sweep at reset settings
    write_settings(make_settings(1'b1, 0, 1'b0, 8, 4000, 95, 1022, 1));
    send_item(make_item(OP_MEASURE, 1'b0, 0,    4095, 0));     // idle, DAC pinned at 0
    send_item(make_item(OP_MEASURE, 1'b1, 4095, 0,    4095));  // idle, latch still 0
    send_item(make_item(OP_MEASURE, 1'b0, 4095, 0,    0));     // idle, step up
    send_item(make_item(OP_START,   1'b0, 0,    0,    0));     // no supply
    send_item(make_item(OP_START,   1'b1, 4095, 4095, 4095));  // sweep starts
    send_item(make_item(OP_START,   1'b1, 0,    0,    0));     // start while busy
    send_item(make_item(OP_MEASURE, 1'b0, 2000, 2005, 0));     // zeroing done
    send_item(make_item(OP_MEASURE, 1'b1, 4095, 1234, 2000));  // up sample
    send_item(make_item(OP_MEASURE, 1'b0, 0,    4095, 4095));  // over-current high
    send_item(make_item(OP_MEASURE, 1'b1, 100,  95,   0));     // middle zeroing
    send_item(make_item(OP_MEASURE, 1'b1, 0,    4095, 2000));  // down sample
    send_item(make_item(OP_MEASURE, 1'b0, 0,    0,    94));    // over-current low
    send_item(make_item(OP_MEASURE, 1'b1, 3000, 3100, 0));     // final zeroing, too far
    send_item(make_item(OP_MEASURE, 1'b0, 0,    3008, 0));     // sweep ends
    send_item(make_item(OP_MEASURE, 1'b1, 4095, 4095, 4095));  // idle tracking again
    drain_results();

    // random sweeps under each setting and idle/stall mix
    for (int p = 0; p < PHASES; p++) begin
      write_settings(settings[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 63; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_item(next_item());
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    $display("Ran %0d transactions: a directed sweep plus random sweeps over %0d settings,",
             items_sent, PHASES);
    $display("with sender gaps, result stalls and a %0d-cycle result hold-off.", HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
